// File: rtl/core/mit_pkg.sv
package mit_pkg;

    localparam int CW = 16;

    typedef struct packed {
        logic signed [CW-1:0] vert_a_x;
        logic signed [CW-1:0] vert_a_y;
        logic signed [CW-1:0] vert_a_z;
        logic signed [CW-1:0] vert_b_x;
        logic signed [CW-1:0] vert_b_y;
        logic signed [CW-1:0] vert_b_z;
        logic signed [CW-1:0] vert_c_x;
        logic signed [CW-1:0] vert_c_y;
        logic signed [CW-1:0] vert_c_z;
        logic                 last_triangle;
    } t_tri;

    typedef struct packed {
        logic signed [31:0] inertia_xx;
        logic signed [31:0] inertia_yy;
        logic signed [31:0] inertia_zz;
        logic signed [31:0] inertia_xy;
        logic signed [31:0] inertia_yz;
        logic signed [31:0] inertia_zx;
        logic               volume_zero;
    } t_res;

    localparam logic [1:0] REG_MASS = 2'd0;
    localparam logic [1:0] REG_SX   = 2'd1;
    localparam logic [1:0] REG_SY   = 2'd2;
    localparam logic [1:0] REG_SZ   = 2'd3;

    localparam logic [63:0] C6  = 64'd3074457345618258603;
    localparam logic [63:0] C10 = 64'd1844674407370955162;
    localparam logic [63:0] C20 = 64'd922337203685477581;

endpackage

// File: rtl/core/mesh_inertia_tensor.sv
// per triangle: 76 multiplies on one shared 64x64 multiplier (four 32x32 partial
// products per multiply)
// a last triangle adds, per entry, a multiply, a 64 step division and a scaling
// multiply, then the result is output
// a new triangle is taken only once the previous one is done; a two entry queue decouples the input
// reset: synchronous active low, clears sums, queue and control; config to 1.0
module mesh_inertia_tensor (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  mit_pkg::t_tri  i_tri,
    output logic           empty,
    input  logic           pop,
    output mit_pkg::t_res  o_res,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [31:0]    i_cfg_data
);
    import mit_pkg::*;

    logic [31:0] r_mass;
    logic [23:0] r_sx, r_sy, r_sz;
    logic        w_avail, w_take, w_valid;
    t_tri        w_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass <= 32'd65536; r_sx <= 24'd65536; r_sy <= 24'd65536;
            r_sz <= 24'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MASS: r_mass <= i_cfg_data;
                REG_SX:   r_sx <= i_cfg_data[23:0];
                REG_SY:   r_sy <= i_cfg_data[23:0];
                REG_SZ:   r_sz <= i_cfg_data[23:0];
            endcase
        end
    end

    mit_front u_front (.i_clk, .i_rst_n, .i_push(push),
                       .o_full(full), .i_item(i_tri), .o_avail(w_avail),
                       .i_take(w_take), .o_item(w_item));

    mit_back u_back (.i_clk, .i_rst_n, .i_avail(w_avail), .o_take(w_take),
                     .i_item(w_item), .i_mass(r_mass), .i_sx(r_sx), .i_sy(r_sy),
                     .i_sz(r_sz), .o_valid(w_valid), .o_res(o_res),
                     .i_res_taken(pop));

    assign empty = !w_valid;
endmodule

// File: rtl/core/mit_mul.sv
// 64x64 signed or unsigned product, one 32x32 partial product a cycle
module mit_mul (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_sgn,
    input  logic [63:0]   i_a,
    input  logic [63:0]   i_b,
    output logic          o_done,
    output logic [127:0]  o_p
);
    logic [2:0]   r_cnt;
    logic         r_busy;
    logic [63:0]  r_a, r_b;
    logic         r_sgn;
    logic [127:0] r_acc;
    logic [31:0]  w_x, w_y;
    logic [63:0]  w_pp;
    logic [127:0] w_sh;

    always_comb begin
        w_x  = r_cnt[0] ? r_a[63:32] : r_a[31:0];
        w_y  = r_cnt[1] ? r_b[63:32] : r_b[31:0];
        w_pp = {32'd0, w_x} * {32'd0, w_y};
        w_sh = {64'd0, w_pp} << (7'(r_cnt[0] + r_cnt[1]) * 7'd32);
    end

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_a    <= i_a;
            r_b    <= i_b;
            r_sgn  <= i_sgn;
            r_acc  <= '0;
        end else if (r_busy) begin
            if (r_cnt == 3'd4) begin
                // signed correction on the upper half
                o_p <= r_acc - ((r_sgn && r_a[63]) ? {r_b, 64'd0} : 128'd0)
                             - ((r_sgn && r_b[63]) ? {r_a, 64'd0} : 128'd0);
                o_done <= 1'b1;
                r_busy <= 1'b0;
            end else begin
                r_acc <= r_acc + w_sh;
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end
endmodule

// File: rtl/core/mit_front.sv
// front: takes triangles into a two entry queue
module mit_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  mit_pkg::t_tri   i_item,
    output logic            o_avail,
    input  logic            i_take,
    output mit_pkg::t_tri   o_item
);
    import mit_pkg::*;
    t_tri r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_avail = r_cnt != 2'd0;
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_q[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= ~r_wp;
            if (i_take && o_avail) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'((i_push && !o_full) ? 1 : 0)
                           - 2'((i_take && o_avail) ? 1 : 0);
        end
    end
endmodule

// File: rtl/core/mit_back.sv
// back: sequencer over one shared multiplier and a bit-serial divider
module mit_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_avail,
    output logic           o_take,
    input  mit_pkg::t_tri  i_item,
    input  logic [31:0]    i_mass,
    input  logic [23:0]    i_sx,
    input  logic [23:0]    i_sy,
    input  logic [23:0]    i_sz,
    output logic           o_valid,
    output mit_pkg::t_res  o_res,
    input  logic           i_res_taken
);
    import mit_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_WAIT = 4'd2, S_DIV = 4'd3,
                           S_OUT = 4'd4;

    logic [3:0]  r_st;
    logic [6:0]  r_op;      // micro step
    logic [63:0] r_v [24];  // scratch regs
    logic [63:0] r_vol;
    logic [63:0] r_m [6];
    logic        r_last;
    logic [2:0]  r_e;       // entry in finish
    logic [6:0]  r_dc;
    logic [63:0] r_rem, r_q, r_lo, r_d;
    logic [31:0] r_out [6];
    logic        r_vz;

    logic         w_start, w_sgn, w_done;
    logic [63:0]  w_a, w_b;
    logic [127:0] w_p;

    mit_mul u_mul (.i_clk, .i_rst_n, .i_start(w_start), .i_sgn(w_sgn), .i_a(w_a),
                   .i_b(w_b), .o_done(w_done), .o_p(w_p));

    function automatic logic [63:0] sx64(input logic [CW-1:0] v);
        return {{(64-CW){v[CW-1]}}, v};
    endfunction

    // v0..8 coords, v9.. temps
    // op table: returns operands and result slot
    logic [4:0] w_ia, w_ib, w_dst;
    logic [1:0] w_mode;     // 0 lo, 1 >>60; codes 2 and 3 also give lo
    logic [63:0] w_kb;
    logic        w_useK;

    always_comb begin
        w_ia = '0; w_ib = '0; w_dst = '0; w_mode = 2'd0; w_useK = 1'b0; w_kb = C6;
        unique case (r_op)
            // cross products: 9..14
            7'd0:  begin w_ia=5'd4; w_ib=5'd8; w_dst=5'd9;  end
            7'd1:  begin w_ia=5'd5; w_ib=5'd7; w_dst=5'd10; end
            7'd2:  begin w_ia=5'd5; w_ib=5'd6; w_dst=5'd11; end
            7'd3:  begin w_ia=5'd3; w_ib=5'd8; w_dst=5'd12; end
            7'd4:  begin w_ia=5'd3; w_ib=5'd7; w_dst=5'd13; end
            7'd5:  begin w_ia=5'd4; w_ib=5'd6; w_dst=5'd14; end
            // dot products into 15..17 (operands 9,11,13 hold cross after fix)
            7'd6:  begin w_ia=5'd0; w_ib=5'd9;  w_dst=5'd15; end
            7'd7:  begin w_ia=5'd1; w_ib=5'd11; w_dst=5'd16; end
            7'd8:  begin w_ia=5'd2; w_ib=5'd13; w_dst=5'd17; end
            7'd9:  begin w_ia=5'd15; w_useK=1'b1; w_kb=C6; w_mode=2'd1; w_dst=5'd18; end
            default: ;
        endcase
    end

    // each sum builds in r_s; processed by separate counters
    logic [2:0]  r_k;       // moment index 0..5
    logic [3:0]  r_j;       // product index within sum 0..8
    logic [1:0]  r_ph;      // 0 build sum, 1 *dv, 2 *C
    logic [63:0] r_s;

    // coordinate selects for sum building
    logic [4:0] w_ua, w_ub;
    logic [1:0] w_au, w_av;
    logic [1:0] w_i, w_jj;
    always_comb begin
        // axes: k<3 square sums of axis k; k>=3 pairs xy,yz,zx
        w_au = (r_k < 3'd3) ? r_k[1:0] : ((r_k == 3'd3) ? 2'd0 : (r_k == 3'd4) ? 2'd1 : 2'd2);
        w_av = (r_k < 3'd3) ? r_k[1:0] : ((r_k == 3'd3) ? 2'd1 : (r_k == 3'd4) ? 2'd2 : 2'd0);
        w_i  = (r_j < 4'd3) ? 2'd0 : (r_j < 4'd6) ? 2'd1 : 2'd2;
        w_jj = 2'(r_j - {2'd0, w_i} * 4'd3);
        w_ua = 5'(w_i) * 5'd3 + 5'(w_au);
        w_ub = 5'(w_jj) * 5'd3 + 5'(w_av);
    end
    // square sum uses pairs i<=j only (6 terms); pair sum all 9 with diag doubled
    logic w_skip, w_dbl;
    assign w_skip = (r_k < 3'd3) && (w_jj < w_i);
    assign w_dbl  = (r_k >= 3'd3) && (w_jj == w_i);

    logic [63:0] w_dv;
    assign w_dv = r_v[18];

    always_comb begin
        w_start = 1'b0; w_sgn = 1'b1; w_a = '0; w_b = '0;
        if (r_st == S_MUL) begin
            w_start = 1'b1;
            if (r_op < 7'd10) begin
                w_a = r_v[w_ia];
                w_b = w_useK ? w_kb : r_v[w_ib];
            end else if (r_op == 7'd10) begin
                if (r_ph == 2'd0) begin w_a = r_v[w_ua]; w_b = r_v[w_ub]; end
                else if (r_ph == 2'd1) begin w_a = r_s; w_b = w_dv; end
                else begin w_a = r_s; w_b = (r_k < 3'd3) ? C10 : C20; end
            end else begin
                // finish phases
                w_sgn = 1'b0;
                unique case (r_ph)
                    2'd0: begin w_a = r_m[r_e][63] ? -r_m[r_e] : r_m[r_e];
                                w_b = {32'd0, i_mass}; end
                    2'd1: begin
                        w_a = r_q;
                        unique case (r_e)
                            3'd0: w_b = {40'd0, i_sx} * {40'd0, i_sx};
                            3'd1: w_b = {40'd0, i_sy} * {40'd0, i_sy};
                            3'd2: w_b = {40'd0, i_sz} * {40'd0, i_sz};
                            3'd3: w_b = {40'd0, i_sx} * {40'd0, i_sy};
                            3'd4: w_b = {40'd0, i_sy} * {40'd0, i_sz};
                            default: w_b = {40'd0, i_sz} * {40'd0, i_sx};
                        endcase
                    end
                    default: ;
                endcase
            end
        end
    end

    logic [63:0] w_res;
    always_comb begin
        unique case (w_mode)
            2'd1: w_res = w_p[123:60];
            default: w_res = w_p[63:0];
        endcase
    end

    logic [63:0] w_vm, w_rs, w_mag, w_dvq;
    logic        w_neg;
    assign w_vm = r_vol[63] ? -r_vol : r_vol;
    assign w_rs = {r_rem[62:0], r_lo[63]};
    assign w_neg = r_m[r_e][63] ^ r_vol[63];
    assign w_dvq = w_p[127:64];
    assign w_mag = (w_p[127:96] != 32'd0) ? '1 : w_p[95:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_op <= '0; o_valid <= 1'b0; r_vol <= '0;
            for (int i = 0; i < 6; i++) r_m[i] <= '0;
        end else begin
            if (o_valid && i_res_taken) o_valid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_avail) begin
                    r_v[0] <= sx64(i_item.vert_a_x); r_v[1] <= sx64(i_item.vert_a_y);
                    r_v[2] <= sx64(i_item.vert_a_z); r_v[3] <= sx64(i_item.vert_b_x);
                    r_v[4] <= sx64(i_item.vert_b_y); r_v[5] <= sx64(i_item.vert_b_z);
                    r_v[6] <= sx64(i_item.vert_c_x); r_v[7] <= sx64(i_item.vert_c_y);
                    r_v[8] <= sx64(i_item.vert_c_z);
                    r_last <= i_item.last_triangle;
                    r_op <= '0; r_k <= '0; r_j <= '0; r_ph <= '0; r_s <= '0;
                    r_st <= S_MUL;
                end
                S_MUL: r_st <= S_WAIT;
                S_WAIT: if (w_done) begin
                    r_st <= S_MUL;
                    if (r_op < 7'd10) begin
                        r_v[w_dst] <= w_res;
                        r_op <= r_op + 7'd1;
                        if (r_op == 7'd5) begin
                            r_v[9]  <= r_v[9] - r_v[10];
                            r_v[11] <= r_v[11] - r_v[12];
                            r_v[13] <= r_v[13] - w_res;
                        end
                        // dot product sum lands in slot 15 for the volume step
                        if (r_op == 7'd8) r_v[15] <= r_v[15] + r_v[16] + w_res;
                        if (r_op == 7'd9) r_vol <= r_vol + w_res;
                    end else if (r_op == 7'd10) begin
                        if (r_ph == 2'd0) begin
                            if (!w_skip)
                                r_s <= r_s + (w_dbl ? {w_p[62:0], 1'b0} : w_p[63:0]);
                            if (r_j == 4'd8) r_ph <= 2'd1;
                            else r_j <= r_j + 4'd1;
                        end else if (r_ph == 2'd1) begin
                            r_s <= w_p[87:24]; r_ph <= 2'd2;
                        end else begin
                            if (r_k < 3'd3) begin
                                for (int a = 0; a < 3; a++)
                                    if (a != int'(r_k)) r_m[a] <= r_m[a] + w_dvq;
                            end else r_m[r_k] <= r_m[r_k] - w_dvq;
                            r_s <= '0; r_j <= '0; r_ph <= 2'd0;
                            if (r_k == 3'd5) begin
                                if (!r_last) r_st <= S_IDLE;
                                else if (r_vol == 64'd0) begin
                                    for (int i = 0; i < 6; i++) r_out[i] <= '0;
                                    r_vz <= 1'b1; r_st <= S_OUT;
                                end else begin
                                    r_vz <= 1'b0; r_op <= 7'd11; r_e <= '0;
                                end
                            end else r_k <= r_k + 3'd1;
                        end
                    end else begin
                        if (r_ph == 2'd0) begin
                            r_rem <= w_p[127:64]; r_lo <= w_p[63:0];
                            r_q <= '0; r_dc <= '0; r_st <= S_DIV;
                        end else begin
                            if (w_neg) r_out[r_e] <= (w_mag > 64'h80000000) ?
                                32'h80000000 : 32'(-w_mag);
                            else r_out[r_e] <= (w_mag > 64'h7fffffff) ?
                                32'h7fffffff : w_mag[31:0];
                            r_ph <= 2'd0;
                            if (r_e == 3'd5) r_st <= S_OUT;
                            else r_e <= r_e + 3'd1;
                        end
                    end
                end
                S_DIV: begin
                    // restoring division, one bit a cycle
                    if (r_dc == 7'd0 && r_rem >= w_vm) begin
                        r_q <= '1; r_ph <= 2'd1; r_st <= S_MUL;
                    end else begin
                        r_rem <= (r_rem[63] || w_rs >= w_vm) ? w_rs - w_vm : w_rs;
                        r_q   <= {r_q[62:0], (r_rem[63] || w_rs >= w_vm)};
                        r_lo  <= {r_lo[62:0], 1'b0};
                        r_dc  <= r_dc + 7'd1;
                        if (r_dc == 7'd63) begin r_ph <= 2'd1; r_st <= S_MUL; end
                    end
                end
                S_OUT: if (!o_valid) begin
                    o_valid <= 1'b1;
                    o_res <= '{r_out[0], r_out[1], r_out[2], r_out[3], r_out[4],
                               r_out[5], r_vz};
                    // mesh done, clear the sums
                    r_vol <= '0;
                    for (int i = 0; i < 6; i++) r_m[i] <= '0;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_take = (r_st == S_IDLE) && i_avail;
endmodule
